@@ rtl/core/i2cm_pkg.sv @@
package i2cm_pkg;

  // Default depth of the transmit byte queue.
  localparam int unsigned FIFO_DEPTH_DEF = 16;

  // The low three bits of a raw bus status are ignored.
  localparam logic [7:0] STATUS_MASK = 8'hF8;
  // Read/write bit in the address byte.
  localparam logic [7:0] RW_BIT = 8'h01;

  // Bus status codes that each phase expects.
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
  localparam logic [7:0] ST_MT_DAT_ACK  = 8'h28;
  localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;
  localparam logic [7:0] ST_MR_DAT_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DAT_NACK = 8'h58;

  // Item kinds.
  typedef enum logic [1:0] {
    OP_PUSH        = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_START_READ  = 2'd2,
    OP_BUS_EVENT   = 2'd3
  } op_e;

  // Sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_STARTW   = 4'd1,
    PH_ADDRW    = 4'd2,
    PH_BYTEW    = 4'd3,
    PH_STARTR   = 4'd4,
    PH_ADDRR    = 4'd5,
    PH_BYTER    = 4'd6,
    PH_LASTR    = 4'd7,
    PH_FINISHED = 4'd8,
    PH_ERROR    = 4'd9
  } phase_e;

  // Bus commands.
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_e;

  // One input item.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] slave_address;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic [7:0] bus_status;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic [3:0] fsm_state;
    logic       push_failed;
  } out_item_t;

endpackage

@@ rtl/core/i2c_master_transaction_fsm.sv @@
// Byte-level I2C master sequencer.
// The input channel (in_valid_i, in_stall_o, in_item_i) takes one item per
// cycle while in_stall_o is low: push a transmit byte, start a write, start
// a read, or report a bus event with its raw status and received byte. Every
// item gives exactly one result on the output channel (out_valid_o,
// out_stall_i, out_item_o) with the next bus command, any received byte with
// its index, the phase after the item and a push failure flag.
// Each result is registered when its item is accepted. Throughput is one item
// per cycle while in_stall_o is low, set by the single read and single write
// port of the transmit byte memory, which a bus event reads at the queue head
// in the same edge that the item is accepted.
// Reset puts the sequencer in idle with an empty queue; the queue memory is
// never read before it is written, so it needs no clearing pass.
// When the receiver stalls, one further item is still taken and the older
// result moves to a skid register; in_stall_o then stays high until that result is taken.
module i2c_master_transaction_fsm
  import i2cm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);

  // Control state.
  phase_e            phase_q, phase_d;
  logic [7:0]        target_q, target_d;
  logic [7:0]        total_q, total_d;
  logic [7:0]        done_q, done_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Transmit byte memory and its registered read data.
  logic [7:0] fifo_mem_q [FIFO_DEPTH];
  logic [7:0] rdata_q;

  // Result stage and skid stage.
  logic      a_valid_q, a_pop_q;
  out_item_t a_q, a_comp;
  logic      s_valid_q;
  out_item_t s_q;

  logic       in_accept, out_take;
  logic       push_wr, pop_rd;
  logic [7:0] status;
  logic [7:0] done_inc;
  out_item_t  res;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_stall_o = s_valid_q;
  assign in_accept  = in_valid_i && !s_valid_q;
  assign status     = in_item_i.bus_status & STATUS_MASK;
  assign done_inc   = done_q + 8'd1;

  // Next state and the result of the item at the input.
  always_comb begin
    phase_d  = phase_q;
    target_d = target_q;
    total_d  = total_q;
    done_d   = done_q;
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    push_wr  = 1'b0;
    pop_rd   = 1'b0;
    res      = '0;
    case (op_e'(in_item_i.op))
      OP_PUSH: begin
        if (fill_q == FILL_FULL) begin
          res.push_failed = 1'b1;
        end else begin
          push_wr = 1'b1;
          tail_d  = ptr_next(tail_q);
          fill_d  = fill_q + FILL_W'(1);
        end
      end
      OP_START_WRITE: begin
        target_d        = in_item_i.slave_address;
        phase_d         = PH_STARTW;
        res.bus_command = CMD_START;
      end
      OP_START_READ: begin
        target_d        = in_item_i.slave_address;
        total_d         = (in_item_i.byte_count == 8'd0) ? 8'd1 : in_item_i.byte_count;
        done_d          = 8'd0;
        phase_d         = PH_STARTR;
        res.bus_command = CMD_START;
      end
      OP_BUS_EVENT: begin
        case (phase_q)
          PH_STARTW: begin
            if (status != ST_START) begin
              phase_d = PH_ERROR;
            end else begin
              phase_d         = PH_ADDRW;
              res.tx_byte     = target_q & ~RW_BIT;
              res.bus_command = CMD_SEND;
            end
          end
          PH_ADDRW, PH_BYTEW: begin
            if (status != ((phase_q == PH_ADDRW) ? ST_MT_SLA_ACK : ST_MT_DAT_ACK)) begin
              phase_d = PH_ERROR;
            end else if (fill_q != '0) begin
              // Next data byte comes from the queue head via the registered read data.
              pop_rd          = 1'b1;
              head_d          = ptr_next(head_q);
              fill_d          = fill_q - FILL_W'(1);
              phase_d         = PH_BYTEW;
              res.bus_command = CMD_SEND;
            end else begin
              phase_d         = PH_FINISHED;
              res.bus_command = CMD_STOP;
            end
          end
          PH_STARTR: begin
            if (status != ST_START) begin
              phase_d = PH_ERROR;
            end else begin
              target_d        = target_q | RW_BIT;
              phase_d         = PH_ADDRR;
              res.tx_byte     = target_q | RW_BIT;
              res.bus_command = CMD_SEND;
            end
          end
          PH_ADDRR: begin
            if (status != ST_MR_SLA_ACK) begin
              phase_d = PH_ERROR;
            end else if ({1'b0, done_q} + 9'd1 < {1'b0, total_q}) begin
              phase_d         = PH_BYTER;
              res.bus_command = CMD_RX_ACK;
            end else begin
              phase_d         = PH_LASTR;
              res.bus_command = CMD_RX_NACK;
            end
          end
          PH_BYTER: begin
            if (status != ST_MR_DAT_ACK) begin
              phase_d = PH_ERROR;
            end else begin
              res.rx_valid = 1'b1;
              res.rx_byte  = in_item_i.data_byte;
              res.rx_index = done_q;
              done_d       = done_inc;
              if ({1'b0, done_inc} + 9'd1 < {1'b0, total_q}) begin
                phase_d         = PH_BYTER;
                res.bus_command = CMD_RX_ACK;
              end else begin
                phase_d         = PH_LASTR;
                res.bus_command = CMD_RX_NACK;
              end
            end
          end
          PH_LASTR: begin
            if (status != ST_MR_DAT_NACK) begin
              phase_d = PH_ERROR;
            end else begin
              res.rx_valid    = 1'b1;
              res.rx_byte     = in_item_i.data_byte;
              res.rx_index    = done_q;
              done_d          = done_inc;
              phase_d         = PH_FINISHED;
              res.bus_command = CMD_STOP;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res.fsm_state = phase_d;
  end

  // Control state register, updated per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      target_q <= '0;
      total_q  <= '0;
      done_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
    end else if (in_accept) begin
      phase_q  <= phase_d;
      target_q <= target_d;
      total_q  <= total_d;
      done_q   <= done_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
    end
  end

  // Transmit byte memory: one write port at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (in_accept && push_wr) begin
      fifo_mem_q[tail_q] <= in_item_i.data_byte;
    end
    if (in_accept && pop_rd) begin
      rdata_q <= fifo_mem_q[head_q];
    end
  end

  // Result with the popped byte merged in.
  always_comb begin
    a_comp = a_q;
    if (a_pop_q) begin
      a_comp.tx_byte = rdata_q;
    end
  end

  // Output side: the skid register holds the older result when present.
  assign out_valid_o = s_valid_q || a_valid_q;
  assign out_item_o  = s_valid_q ? s_q : a_comp;
  assign out_take    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (s_valid_q) begin
      s_valid_q <= !out_take;
    end else begin
      a_valid_q <= in_accept || (a_valid_q && !out_take);
      s_valid_q <= a_valid_q && !out_take && in_accept;
    end
  end

  // Payload of the two output stages.
  always_ff @(posedge clk_i) begin
    if (!s_valid_q && a_valid_q && !out_take && in_accept) begin
      s_q <= a_comp;
    end
    if (in_accept) begin
      a_q     <= res;
      a_pop_q <= pop_rd;
    end
  end

endmodule

@@ test/i2cm_sequence_checker.sv @@
// Watches both channels of the sequencer, predicts one result per accepted
// item and compares every accepted result with the oldest prediction.
module i2cm_sequence_checker
  import i2cm_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Predicted sequencer state.
  phase_e      seq_phase;
  logic [7:0]  target_addr;
  logic [7:0]  bytes_wanted;
  logic [7:0]  bytes_taken;
  logic [7:0]  tx_queue_mem [FIFO_DEPTH];
  int unsigned q_head;
  int unsigned q_tail;
  int unsigned q_fill;

  // Results still owed by the block, oldest first.
  out_item_t results_due [$];
  out_item_t predicted;
  out_item_t oldest;
  int        mismatches = 0;
  int        outstanding = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  task automatic clear_sequencer();
    seq_phase    = PH_IDLE;
    target_addr  = '0;
    bytes_wanted = '0;
    bytes_taken  = '0;
    q_head       = 0;
    q_tail       = 0;
    q_fill       = 0;
  endtask

  // After an address or data ack: send the next queued byte, or stop.
  task automatic advance_write(inout out_item_t res);
    if (q_fill != 0) begin
      res.tx_byte     = tx_queue_mem[q_head];
      q_head          = (q_head + 1) % FIFO_DEPTH;
      q_fill          = q_fill - 1;
      seq_phase       = PH_BYTEW;
      res.bus_command = CMD_SEND;
    end else begin
      seq_phase       = PH_FINISHED;
      res.bus_command = CMD_STOP;
    end
  endtask

  // Ack every byte but the last one of the read.
  task automatic advance_read(inout out_item_t res);
    if (int'(bytes_taken) + 1 < int'(bytes_wanted)) begin
      seq_phase       = PH_BYTER;
      res.bus_command = CMD_RX_ACK;
    end else begin
      seq_phase       = PH_LASTR;
      res.bus_command = CMD_RX_NACK;
    end
  endtask

  task automatic deliver_byte(input in_item_t it, inout out_item_t res);
    res.rx_valid = 1'b1;
    res.rx_byte  = it.data_byte;
    res.rx_index = bytes_taken;
    bytes_taken  = bytes_taken + 8'd1;
  endtask

  // Computes the result of one item and moves the predicted state on.
  task automatic step_sequencer(input in_item_t it, output out_item_t res);
    logic [7:0] status;
    status = it.bus_status & STATUS_MASK;
    res = '0;
    case (op_e'(it.op))
      OP_PUSH: begin
        if (q_fill >= FIFO_DEPTH) begin
          res.push_failed = 1'b1;
        end else begin
          tx_queue_mem[q_tail] = it.data_byte;
          q_tail = (q_tail + 1) % FIFO_DEPTH;
          q_fill = q_fill + 1;
        end
      end
      OP_START_WRITE: begin
        target_addr     = it.slave_address;
        seq_phase       = PH_STARTW;
        res.bus_command = CMD_START;
      end
      OP_START_READ: begin
        target_addr     = it.slave_address;
        bytes_wanted    = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
        bytes_taken     = '0;
        seq_phase       = PH_STARTR;
        res.bus_command = CMD_START;
      end
      default: begin
        case (seq_phase)
          PH_STARTW: begin
            if (status != ST_START) begin
              seq_phase = PH_ERROR;
            end else begin
              seq_phase       = PH_ADDRW;
              res.tx_byte     = target_addr & ~RW_BIT;
              res.bus_command = CMD_SEND;
            end
          end
          PH_ADDRW: begin
            if (status != ST_MT_SLA_ACK) seq_phase = PH_ERROR;
            else advance_write(res);
          end
          PH_BYTEW: begin
            if (status != ST_MT_DAT_ACK) seq_phase = PH_ERROR;
            else advance_write(res);
          end
          PH_STARTR: begin
            if (status != ST_START) begin
              seq_phase = PH_ERROR;
            end else begin
              target_addr     = target_addr | RW_BIT;
              seq_phase       = PH_ADDRR;
              res.tx_byte     = target_addr;
              res.bus_command = CMD_SEND;
            end
          end
          PH_ADDRR: begin
            if (status != ST_MR_SLA_ACK) seq_phase = PH_ERROR;
            else advance_read(res);
          end
          PH_BYTER: begin
            if (status != ST_MR_DAT_ACK) begin
              seq_phase = PH_ERROR;
            end else begin
              deliver_byte(it, res);
              advance_read(res);
            end
          end
          PH_LASTR: begin
            if (status != ST_MR_DAT_NACK) begin
              seq_phase = PH_ERROR;
            end else begin
              deliver_byte(it, res);
              seq_phase       = PH_FINISHED;
              res.bus_command = CMD_STOP;
            end
          end
          // Bus events in idle, finished and error are ignored.
          default: ;
        endcase
      end
    endcase
    res.fsm_state = seq_phase;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted item, compare on every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_sequencer();
      results_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        step_sequencer(in_item_i, predicted);
        results_due.push_back(predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result item accepted with no item outstanding");
          mismatches++;
        end else begin
          oldest = results_due.pop_front();
          check_field("bus_command", oldest.bus_command, out_item_i.bus_command);
          check_field("tx_byte", oldest.tx_byte, out_item_i.tx_byte);
          check_field("rx_valid", oldest.rx_valid, out_item_i.rx_valid);
          check_field("rx_byte", oldest.rx_byte, out_item_i.rx_byte);
          check_field("rx_index", oldest.rx_index, out_item_i.rx_index);
          check_field("fsm_state", oldest.fsm_state, out_item_i.fsm_state);
          check_field("push_failed", oldest.push_failed, out_item_i.push_failed);
        end
      end
    end
    outstanding = results_due.size();
  end

endmodule

@@ test/i2c_master_transaction_fsm_tb.sv @@
// Drives write and read transfers, byte pushes and stray items into the
// sequencer with random gaps and output stalls; the checker does the rest.
module i2c_master_transaction_fsm_tb
  import i2cm_pkg::*;
;

  localparam int ITEM_TARGET   = 1950;
  localparam int QUIET_FROM    = 1700;
  localparam int HOLD_FROM     = 600;
  localparam int PAUSE_FROM    = 1200;
  localparam int HOLD_CYCLES   = 80;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 600000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int fail_count;
  int pending;

  // Stimulus bookkeeping shared by the sender and the receiver.
  int sent_count = 0;
  int queued = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit paused = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  i2c_master_transaction_fsm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  i2cm_sequence_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one item, sometimes after a random gap, and waits until it is taken.
  task automatic offer_item(input in_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    sent_count++;
  endtask

  task automatic offer_fields(input op_e op, input logic [7:0] addr,
                              input logic [7:0] count, input logic [7:0] data,
                              input logic [7:0] status);
    in_item_t it;
    it.op            = op;
    it.slave_address = addr;
    it.byte_count    = count;
    it.data_byte     = data;
    it.bus_status    = status;
    offer_item(it);
  endtask

  function automatic in_item_t random_item(input op_e op);
    in_item_t it;
    it.op            = op;
    it.slave_address = 8'($urandom_range(0, 255));
    it.byte_count    = 8'($urandom_range(0, 255));
    it.data_byte     = 8'($urandom_range(0, 255));
    it.bus_status    = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // One bus event with the given code; now and then the status is corrupted
  // or the transfer is cut short so that the next start lands mid-sequence.
  task automatic issue_event(input logic [7:0] code, output bit broken);
    in_item_t it;
    int roll;
    it = random_item(OP_BUS_EVENT);
    roll = $urandom_range(0, 59);
    broken = (roll < 2);
    if (roll != 1) begin
      if (roll != 0) it.bus_status = code | 8'($urandom_range(0, 7));
      offer_item(it);
    end
  endtask

  task automatic push_byte();
    in_item_t it;
    it = random_item(OP_PUSH);
    offer_item(it);
    if (queued < FIFO_DEPTH_DEF) queued++;
  endtask

  // Push bytes into the byte queue, then walk a write transfer.
  task automatic run_write();
    in_item_t it;
    int pushes;
    bit broken;
    pushes = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 4);
    repeat (pushes) push_byte();
    it = random_item(OP_START_WRITE);
    offer_item(it);
    issue_event(ST_START, broken);
    if (!broken) begin
      issue_event(ST_MT_SLA_ACK, broken);
      while (!broken && queued > 0) begin
        queued--;
        issue_event(ST_MT_DAT_ACK, broken);
      end
    end
  endtask

  // A read transfer, mostly short, seldom the longest count.
  task automatic run_read();
    in_item_t it;
    int pick;
    int total;
    bit broken;
    it = random_item(OP_START_READ);
    pick = $urandom_range(0, 79);
    if (pick == 0) it.byte_count = 8'hFF;
    else if (pick < 10) it.byte_count = 8'h00;
    else it.byte_count = 8'($urandom_range(1, 6));
    total = (it.byte_count == 8'h00) ? 1 : int'(it.byte_count);
    offer_item(it);
    issue_event(ST_START, broken);
    if (!broken) issue_event(ST_MR_SLA_ACK, broken);
    for (int i = 0; i < total - 1 && !broken; i++) begin
      issue_event(ST_MR_DAT_ACK, broken);
    end
    if (!broken) issue_event(ST_MR_DAT_NACK, broken);
  endtask

  // Fully random items between transfers.
  task automatic run_noise();
    in_item_t it;
    repeat ($urandom_range(1, 3)) begin
      it = random_item(op_e'($urandom_range(0, 3)));
      offer_item(it);
      if (it.op == OP_PUSH && queued < FIFO_DEPTH_DEF) queued++;
    end
  endtask

  // Receiver: random stall bursts, one long hold-off, none at the end.
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 19) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("i2c_master_transaction_fsm test failed");
    $finish;
  end

  // Sender: directed items, then random transfers, then the verdict.
  initial begin : sender
    int pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bus event while idle is ignored.
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_START);
    offer_fields(OP_PUSH, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_fields(OP_PUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Write of two bytes; the address keeps its write bit clear.
    offer_fields(OP_START_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, 8'h0F);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MT_DAT_ACK);
    // Empty queue after a data ack gives a stop.
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, 8'h2F);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MT_DAT_ACK);
    // Read count of zero reads one byte.
    offer_fields(OP_START_READ, 8'h00, 8'h00, 8'h00, 8'h00);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_START);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MR_SLA_ACK);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'hFF, 8'h5F);
    // Two byte read.
    offer_fields(OP_START_READ, 8'h5A, 8'h02, 8'h00, 8'h00);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_START);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MR_SLA_ACK);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MR_DAT_ACK);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'hA5, ST_MR_DAT_NACK);
    // Status mismatch, then an ignored event in the error phase.
    offer_fields(OP_START_WRITE, 8'h12, 8'h00, 8'h00, 8'h00);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_MT_SLA_ACK);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_START);
    // Restart while a write is under way.
    offer_fields(OP_START_WRITE, 8'h34, 8'h00, 8'h00, 8'h00);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, ST_START);
    offer_fields(OP_START_READ, 8'h77, 8'h01, 8'h00, 8'h00);
    offer_fields(OP_BUS_EVENT, 8'h00, 8'h00, 8'h00, 8'hFF);

    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= QUIET_FROM) quiet = 1'b1;
      if (sent_count >= HOLD_FROM) hold_req = 1'b1;
      if (!paused && sent_count >= PAUSE_FROM) begin
        // Let the checker count the last item before waiting for the drain.
        in_valid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) run_write();
      else if (pick < 8) run_read();
      else run_noise();
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("i2c_master_transaction_fsm test passed");
    end else begin
      $display("i2c_master_transaction_fsm test failed");
    end
    $finish;
  end

endmodule
